FILE: design/crcx25bs_pkg.sv
// Shared constants for the byte-swapped X.25 CRC block.
// No dependencies; imported by the byte engine and the top level.
package crcx25bs_pkg;

   localparam int CRC_WIDTH  = 16;
   localparam int BYTE_WIDTH = 8;

   localparam logic [CRC_WIDTH-1:0] CRC_POLY   = 16'h8408;
   localparam logic [CRC_WIDTH-1:0] CRC_PRESET = 16'hFFFF;

   // func field codes
   localparam logic FUNC_DATA  = 1'b0;
   localparam logic FUNC_EMPTY = 1'b1;

endpackage

FILE: design/crcx25bs_byte_engine.sv
// Reflected CRC update over one byte, LSB first, eight unrolled steps.
// Depends on crcx25bs_pkg.
module crcx25bs_byte_engine
   import crcx25bs_pkg::*;
(
   input  logic [CRC_WIDTH-1:0]  crc_in,
   input  logic [BYTE_WIDTH-1:0] data_in,
   output logic [CRC_WIDTH-1:0]  crc_out
);

   always_comb begin
      logic [CRC_WIDTH-1:0] c;
      logic                 fb;
      c = crc_in;
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         fb = c[0] ^ data_in[k];
         c  = (c >> 1) ^ (fb ? CRC_POLY : '0);
      end
      crc_out = c;
   end

endmodule

FILE: design/crc16_x25_byte_swapped.sv
// Byte-serial CRC-16/X.25 with inverted, byte-swapped result.
// A request is registered in the input stage and its result in the result register; a
// result-bearing byte holds the input stage while the output is full. Throughput one byte per
// cycle without such a stall, set by the single-byte unrolled update between the registers.
// Reset (synchronous, active high): start value and running CRC to 0xFFFF, both stages empty.
// Depends on crcx25bs_pkg and crcx25bs_byte_engine.
module crc16_x25_byte_swapped
   import crcx25bs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [BYTE_WIDTH-1:0] req_data_byte,
   input  logic                  req_first_byte,
   input  logic                  req_last_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CRC_WIDTH-1:0]  rsp_crc_value,
   input  logic                  csr_write_enable,
   input  logic [CRC_WIDTH-1:0]  csr_write_data
);

   logic [CRC_WIDTH-1:0]  start_value_ff, start_value_in;
   logic [CRC_WIDTH-1:0]  running_crc_ff, running_crc_in;

   // input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_func_ff;
   logic [BYTE_WIDTH-1:0] s1_data_ff;
   logic                  s1_first_ff;
   logic                  s1_last_ff;

   // result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CRC_WIDTH-1:0]  rsp_crc_ff, rsp_crc_in;

   logic [CRC_WIDTH-1:0]  crc_seed;
   logic [CRC_WIDTH-1:0]  crc_next;
   logic [CRC_WIDTH-1:0]  crc_inv;
   logic                  s1_has_rsp;
   logic                  out_free;
   logic                  s1_advance;
   logic                  req_take;

   assign crc_seed = s1_first_ff ? start_value_ff : running_crc_ff;

   crcx25bs_byte_engine u_engine (
      .crc_in  (crc_seed),
      .data_in (s1_data_ff),
      .crc_out (crc_next)
   );

   assign crc_inv    = ~crc_next;
   assign s1_has_rsp = (s1_func_ff == FUNC_EMPTY) || s1_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   // a byte with no result never waits on the output side
   assign s1_advance = s1_valid_ff && (!s1_has_rsp || out_free);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      start_value_in = csr_write_enable ? csr_write_data : start_value_ff;
      s1_valid_in    = req_take || (s1_valid_ff && !s1_advance);

      running_crc_in = running_crc_ff;
      if (s1_advance && (s1_func_ff == FUNC_DATA)) begin
         running_crc_in = crc_next;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_crc_in   = rsp_crc_ff;
      if (s1_advance && s1_has_rsp) begin
         rsp_valid_in = 1'b1;
         if (s1_func_ff == FUNC_EMPTY) begin
            rsp_crc_in = start_value_ff;
         end else begin
            rsp_crc_in = {crc_inv[7:0], crc_inv[15:8]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_value_ff <= CRC_PRESET;
         running_crc_ff <= CRC_PRESET;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         start_value_ff <= start_value_in;
         running_crc_ff <= running_crc_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff  <= req_func;
         s1_data_ff  <= req_data_byte;
         s1_first_ff <= req_first_byte;
         s1_last_ff  <= req_last_byte;
      end
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

   // empty message returns the start value untouched
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_func_ff == FUNC_EMPTY && !csr_write_enable)
      |=> (rsp_valid_ff && rsp_crc_ff == $past(start_value_ff)))
      else $error("empty-message transaction did not return start value");

   // a data byte always lands in the running CRC
   a_running_update: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_func_ff == FUNC_DATA) |=> (running_crc_ff == $past(crc_next)))
      else $error("running CRC not updated by data byte");

   // input stalls only when a result-bearing byte waits behind a full output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_has_rsp && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without output back-pressure");

   // a non-result byte must not create a response
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!(s1_advance && s1_has_rsp) && (!rsp_valid_ff || rsp_ready)) |=> !rsp_valid_ff)
      else $error("response appeared without a finishing transaction");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (running_crc_ff == CRC_PRESET && !s1_valid_ff && !rsp_valid_ff))
      else $error("state not cleared by reset");

endmodule
